@@ hw/rtl/hsai_pkg.sv @@
// hsai_pkg: shared types, constants and helper functions of the hall sensor angle interpolator
// depends on nothing; used by hsai_ctrl, hsai_dpath and the top level
package hsai_pkg;

  // field widths fixed by the interface
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned SPEED_W    = 26;
  localparam int unsigned INC_W      = 24;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;

  localparam int unsigned ANGLE_BITS_DEF = 16;

  // divider runs one quotient bit per cycle over the widest dividend
  localparam int unsigned DIV_STEPS = SPEED_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // register reset values
  localparam logic [INC_W-1:0]    INC_SCALE_RST = 24'd10922667;
  localparam logic [SPEED_W-1:0]  SPD_SCALE_RST = 26'd50000000;
  localparam logic [OFFSET_W-1:0] PHASE_OFS_RST = 16'd40050;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INC_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFS = 2'd2;

  // command codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // hall codes in sector order
  localparam logic [CODE_W-1:0] HALL_S0 = 3'b101;
  localparam logic [CODE_W-1:0] HALL_S1 = 3'b100;
  localparam logic [CODE_W-1:0] HALL_S2 = 3'b110;
  localparam logic [CODE_W-1:0] HALL_S3 = 3'b010;
  localparam logic [CODE_W-1:0] HALL_S4 = 3'b011;
  localparam logic [CODE_W-1:0] HALL_S5 = 3'b001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } hsai_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } hsai_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic period_zero;
  } hsai_stat_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] idx;
  } hsai_sector_t;

  function automatic hsai_sector_t sector_of(input logic [CODE_W-1:0] code);
    hsai_sector_t s;
    s.valid = 1'b1;
    case (code)
      HALL_S0: s.idx = 3'd0;
      HALL_S1: s.idx = 3'd1;
      HALL_S2: s.idx = 3'd2;
      HALL_S3: s.idx = 3'd3;
      HALL_S4: s.idx = 3'd4;
      HALL_S5: s.idx = 3'd5;
      default: begin
        s.valid = 1'b0;
        s.idx   = 3'd0;
      end
    endcase
    return s;
  endfunction

  // rounded sector start angle, evaluated on constants only
  function automatic logic [31:0] sector_angle(input int unsigned k, input int unsigned bits);
    longint unsigned t;
    t = (longint'(k) << bits) + 64'd3;
    return 32'(t / 6);
  endfunction

endpackage

@@ hw/rtl/hall_sensor_angle_interpolator.sv @@
// hall_sensor_angle_interpolator: top level, rotor angle tracking from three hall sensors
// depends on hsai_pkg, hsai_ctrl and hsai_dpath
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  in_     | input     | in_valid/in_stall  | in_command, in_edge_period, in_hall_code
//  out_    | output    | out_valid/out_stall| out_rotor_angle, out_rotor_speed
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// a control tick, like a capture with zero period, skips the divider and goes straight to commit
// a capture with non-zero period runs the divider before commit: the shared radix-2 divider
//   produces one quotient bit per cycle for both quotients over 26 steps
// one item in flight at a time; in_stall is high from transfer until commit
// a finished result waits in the output register while the next item is taken,
//   commit holds back only while that register is full and stalled
// rst_n is synchronous; registers return to their reset values, angle state to zero
module hall_sensor_angle_interpolator #(
  parameter int unsigned ANGLE_BITS = hsai_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [hsai_pkg::PERIOD_W-1:0]   in_edge_period,
  input  logic [hsai_pkg::CODE_W-1:0]     in_hall_code,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsai_pkg::ANGLE_W-1:0]    out_rotor_angle,
  output logic [hsai_pkg::SPEED_W-1:0]    out_rotor_speed,
  // settings write port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hsai_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsai_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hsai_pkg::hsai_cmd_t  cmd;
  hsai_pkg::hsai_stat_t stat;
  logic                 cfg_we;

  // settings are always writable; writes must come only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: accept, divide, commit
  hsai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: settings, divider, angle state, result register
  hsai_dpath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_edge_period (in_edge_period),
    .in_hall_code   (in_hall_code),
    .cmd            (cmd),
    .stat           (stat),
    .rotor_angle    (out_rotor_angle),
    .rotor_speed    (out_rotor_speed)
  );

endmodule

@@ hw/rtl/hsai_ctrl.sv @@
// hsai_ctrl: sequencer of the hall sensor angle interpolator (accept, divide, commit)
// depends on hsai_pkg; drives hsai_dpath through hsai_cmd_t
module hsai_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  hsai_pkg::hsai_stat_t stat,
  output hsai_pkg::hsai_cmd_t  cmd
);

  hsai_pkg::hsai_state_t          state_r, state_nxt;
  logic [hsai_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           can_commit;
  logic                           in_xfer;

  assign in_xfer    = in_valid && (state_r == hsai_pkg::ST_IDLE);
  assign can_commit = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != hsai_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsai_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      hsai_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          if (!stat.is_tick && !stat.period_zero) begin
            state_nxt = hsai_pkg::ST_DIV;
          end else begin
            state_nxt = hsai_pkg::ST_FINISH;
          end
        end
      end
      hsai_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == hsai_pkg::CNT_W'(hsai_pkg::DIV_STEPS - 1)) begin
          state_nxt = hsai_pkg::ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      hsai_pkg::ST_FINISH: begin
        if (can_commit) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = hsai_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hsai_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit while a result is still held");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsai_pkg::ST_DIV) |-> (cnt_r < hsai_pkg::CNT_W'(hsai_pkg::DIV_STEPS)))
    else $error("divider count out of range");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("input taken while item in flight");
`endif

endmodule

@@ hw/rtl/hsai_dpath.sv @@
// hsai_dpath: settings, two-lane radix-2 divider, angle state and result register
// depends on hsai_pkg; sequenced by hsai_ctrl
module hsai_dpath #(
  parameter int unsigned ANGLE_BITS = hsai_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hsai_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsai_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_command,
  input  logic [hsai_pkg::PERIOD_W-1:0]      in_edge_period,
  input  logic [hsai_pkg::CODE_W-1:0]        in_hall_code,
  input  hsai_pkg::hsai_cmd_t                cmd,
  output hsai_pkg::hsai_stat_t               stat,
  output logic [hsai_pkg::ANGLE_W-1:0]       rotor_angle,
  output logic [hsai_pkg::SPEED_W-1:0]       rotor_speed
);

  localparam int unsigned QW = hsai_pkg::SPEED_W;

  logic [hsai_pkg::INC_W-1:0]    inc_scale_r;
  logic [hsai_pkg::SPEED_W-1:0]  spd_scale_r;
  logic [hsai_pkg::OFFSET_W-1:0] phase_ofs_r;

  logic                          cmd_r;
  logic [hsai_pkg::PERIOD_W-1:0] period_r;
  logic [hsai_pkg::CODE_W-1:0]   code_r;

  logic [QW-1:0]                 q_inc_r, q_inc_nxt, q_spd_r, q_spd_nxt;
  logic [hsai_pkg::PERIOD_W-1:0] r_inc_r, r_inc_nxt, r_spd_r, r_spd_nxt;
  logic [hsai_pkg::PERIOD_W:0]   t_inc, t_spd, dvs;

  logic [ANGLE_BITS-1:0]         angle_r, angle_nxt;
  logic [hsai_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [hsai_pkg::SPEED_W-1:0]  speed_r, speed_nxt;
  logic [hsai_pkg::ANGLE_W-1:0]  rotor_angle_r;
  logic [hsai_pkg::SPEED_W-1:0]  rotor_speed_r;

  hsai_pkg::hsai_sector_t        sec;
  logic [ANGLE_BITS-1:0]         sec_ang;

  assign stat.is_tick     = (in_command == hsai_pkg::CMD_TICK);
  assign stat.period_zero = (in_edge_period == '0);

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_scale_r <= hsai_pkg::INC_SCALE_RST;
      spd_scale_r <= hsai_pkg::SPD_SCALE_RST;
      phase_ofs_r <= hsai_pkg::PHASE_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hsai_pkg::REG_INC_SCALE: inc_scale_r <= cfg_wdata[hsai_pkg::INC_W-1:0];
        hsai_pkg::REG_SPD_SCALE: spd_scale_r <= cfg_wdata;
        hsai_pkg::REG_PHASE_OFS: phase_ofs_r <= cfg_wdata[hsai_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // divider: shift one dividend bit into each partial remainder per step
  assign dvs   = {1'b0, period_r};
  assign t_inc = {r_inc_r, q_inc_r[QW-1]};
  assign t_spd = {r_spd_r, q_spd_r[QW-1]};

  always_comb begin
    q_inc_nxt = q_inc_r;
    q_spd_nxt = q_spd_r;
    r_inc_nxt = r_inc_r;
    r_spd_nxt = r_spd_r;
    if (cmd.load) begin
      q_inc_nxt = QW'(inc_scale_r);
      q_spd_nxt = spd_scale_r;
      r_inc_nxt = '0;
      r_spd_nxt = '0;
    end else if (cmd.div_step) begin
      if (t_inc >= dvs) begin
        r_inc_nxt = hsai_pkg::PERIOD_W'(t_inc - dvs);
        q_inc_nxt = {q_inc_r[QW-2:0], 1'b1};
      end else begin
        r_inc_nxt = t_inc[hsai_pkg::PERIOD_W-1:0];
        q_inc_nxt = {q_inc_r[QW-2:0], 1'b0};
      end
      if (t_spd >= dvs) begin
        r_spd_nxt = hsai_pkg::PERIOD_W'(t_spd - dvs);
        q_spd_nxt = {q_spd_r[QW-2:0], 1'b1};
      end else begin
        r_spd_nxt = t_spd[hsai_pkg::PERIOD_W-1:0];
        q_spd_nxt = {q_spd_r[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_inc_r <= q_inc_nxt;
    q_spd_r <= q_spd_nxt;
    r_inc_r <= r_inc_nxt;
    r_spd_r <= r_spd_nxt;
    if (cmd.load) begin
      cmd_r    <= in_command;
      period_r <= in_edge_period;
      code_r   <= in_hall_code;
    end
  end

  // sector start angles are elaboration constants
  assign sec = hsai_pkg::sector_of(code_r);
  always_comb begin
    case (sec.idx)
      3'd0:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(0, ANGLE_BITS));
      3'd1:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(1, ANGLE_BITS));
      3'd2:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(2, ANGLE_BITS));
      3'd3:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(3, ANGLE_BITS));
      3'd4:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(4, ANGLE_BITS));
      3'd5:    sec_ang = ANGLE_BITS'(hsai_pkg::sector_angle(5, ANGLE_BITS));
      default: sec_ang = '0;
    endcase
  end

  always_comb begin
    angle_nxt = angle_r;
    step_nxt  = step_r;
    speed_nxt = speed_r;
    if (cmd_r == hsai_pkg::CMD_TICK) begin
      angle_nxt = angle_r + ANGLE_BITS'(step_r);
    end else begin
      if (period_r != '0) begin
        step_nxt  = (q_inc_r[QW-1:hsai_pkg::STEP_W] != '0) ? '1
                                                           : q_inc_r[hsai_pkg::STEP_W-1:0];
        speed_nxt = q_spd_r;
      end
      if (sec.valid) begin
        angle_nxt = sec_ang + ANGLE_BITS'(phase_ofs_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      step_r  <= '0;
      speed_r <= '0;
    end else if (cmd.commit) begin
      angle_r <= angle_nxt;
      step_r  <= step_nxt;
      speed_r <= speed_nxt;
    end
  end

  // result register, loaded on commit only
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rotor_angle_r <= hsai_pkg::ANGLE_W'(angle_nxt);
      rotor_speed_r <= speed_nxt;
    end
  end

  assign rotor_angle = rotor_angle_r;
  assign rotor_speed = rotor_speed_r;

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for hall_sensor_angle_interpolator, with a directed table and then
// random captures and control ticks, under several register settings and idling patterns
// depends on hsai_pkg and the rtl of hall_sensor_angle_interpolator
`timescale 1ns / 100ps

module tb_top;

  // run shape
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int N_DIRECTED      = 21;
  localparam int DRAIN_CYCLES    = 64;       // well over the length of a divide
  localparam int CYCLE_LIMIT     = 400000;

  // codes outside the six commutation states
  localparam logic [hsai_pkg::CODE_W-1:0] HALL_BAD_LO = 3'b000;
  localparam logic [hsai_pkg::CODE_W-1:0] HALL_BAD_HI = 3'b111;

  typedef struct packed {
    logic [hsai_pkg::ANGLE_W-1:0] angle;
    logic [hsai_pkg::SPEED_W-1:0] speed;
  } rotor_result_t;

  // one row of the directed table; has_value marks a result typed in by hand
  typedef struct packed {
    bit                            has_value;
    logic                          cmd;
    logic [hsai_pkg::PERIOD_W-1:0] period;
    logic [hsai_pkg::CODE_W-1:0]   code;
    logic [hsai_pkg::ANGLE_W-1:0]  angle;
    logic [hsai_pkg::SPEED_W-1:0]  speed;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid       = 1'b0;
  logic                            in_stall;
  logic                            in_command     = hsai_pkg::CMD_CAPTURE;
  logic [hsai_pkg::PERIOD_W-1:0]   in_edge_period = '0;
  logic [hsai_pkg::CODE_W-1:0]     in_hall_code   = HALL_BAD_LO;
  logic                            out_valid;
  logic                            out_stall      = 1'b0;
  logic [hsai_pkg::ANGLE_W-1:0]    out_rotor_angle;
  logic [hsai_pkg::SPEED_W-1:0]    out_rotor_speed;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [hsai_pkg::CFG_IDX_W-1:0]  cfg_index      = hsai_pkg::REG_INC_SCALE;
  logic [hsai_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;

  // bench's own copy of the registers and the tracking state
  logic [hsai_pkg::INC_W-1:0]    inc_scale_m = hsai_pkg::INC_SCALE_RST;
  logic [hsai_pkg::SPEED_W-1:0]  spd_scale_m = hsai_pkg::SPD_SCALE_RST;
  logic [hsai_pkg::OFFSET_W-1:0] phase_ofs_m = hsai_pkg::PHASE_OFS_RST;
  logic [hsai_pkg::ANGLE_W-1:0]  angle_m     = '0;
  logic [hsai_pkg::STEP_W-1:0]   step_m      = '0;
  logic [hsai_pkg::SPEED_W-1:0]  speed_m     = '0;

  rotor_result_t rotor_expect_q[$];
  rotor_result_t rotor_want;
  stim_row_t     directed_rows [N_DIRECTED];
  logic [hsai_pkg::CODE_W-1:0] hall_seq [6];

  int error_count  = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  hall_sensor_angle_interpolator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_edge_period  (in_edge_period),
    .in_hall_code    (in_hall_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rotor_angle (out_rotor_angle),
    .out_rotor_speed (out_rotor_speed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // angle tracking predictor, advanced once per accepted item
  // ---------------------------------------------------------------------------
  function automatic rotor_result_t track_rotor(input logic cmd,
                                                input logic [hsai_pkg::PERIOD_W-1:0] period,
                                                input logic [hsai_pkg::CODE_W-1:0] code);
    logic [hsai_pkg::INC_W-1:0] inc_quot;
    logic [2:0]                 sector_idx;
    logic                       sector_ok;
    logic [31:0]                sector_start;
    rotor_result_t              res;
    if (cmd == hsai_pkg::CMD_CAPTURE) begin
      // zero period keeps the old increment and speed
      if (period != '0) begin
        inc_quot = inc_scale_m / period;
        // increment saturates at the top of its range
        if (inc_quot[hsai_pkg::INC_W-1:hsai_pkg::STEP_W] != '0) begin
          step_m = '1;
        end else begin
          step_m = inc_quot[hsai_pkg::STEP_W-1:0];
        end
        speed_m = spd_scale_m / period;
      end
      sector_ok  = 1'b1;
      sector_idx = 3'd0;
      case (code)
        hsai_pkg::HALL_S0: sector_idx = 3'd0;
        hsai_pkg::HALL_S1: sector_idx = 3'd1;
        hsai_pkg::HALL_S2: sector_idx = 3'd2;
        hsai_pkg::HALL_S3: sector_idx = 3'd3;
        hsai_pkg::HALL_S4: sector_idx = 3'd4;
        hsai_pkg::HALL_S5: sector_idx = 3'd5;
        default: sector_ok = 1'b0;   // all-low and all-high codes leave the angle alone
      endcase
      if (sector_ok) begin
        // sector start rounded to the nearest angle unit, then the offset, wrapping
        sector_start = ((32'(sector_idx) << hsai_pkg::ANGLE_W) + 32'd3) / 32'd6;
        angle_m      = hsai_pkg::ANGLE_W'(sector_start + 32'(phase_ofs_m));
      end
    end else begin
      angle_m = angle_m + step_m;    // wraps modulo one turn
    end
    res.angle = angle_m;
    res.speed = speed_m;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input channel: optional idle gap, then hold the item until its transfer
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [hsai_pkg::PERIOD_W-1:0] period,
                           input logic [hsai_pkg::CODE_W-1:0] code, input bit has_value,
                           input rotor_result_t typed_res);
    rotor_result_t predicted;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_edge_period <= period;
    in_hall_code   <= code;
    do @(posedge clk); while (in_stall);
    // predictor always runs so its state follows the block
    predicted = track_rotor(cmd, period, code);
    rotor_expect_q.push_back(has_value ? typed_res : predicted);
  endtask

  // settings port: valid stays high across back-to-back writes, caller lowers it
  task automatic write_setting(input logic [hsai_pkg::CFG_IDX_W-1:0] idx,
                               input logic [hsai_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hsai_pkg::REG_INC_SCALE: inc_scale_m = data[hsai_pkg::INC_W-1:0];
      hsai_pkg::REG_SPD_SCALE: spd_scale_m = data[hsai_pkg::SPEED_W-1:0];
      hsai_pkg::REG_PHASE_OFS: phase_ofs_m = data[hsai_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random stall and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rotor_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending, angle", out_rotor_angle, 0);
      end else begin
        rotor_want = rotor_expect_q.pop_front();
        if (out_rotor_angle !== rotor_want.angle)
          report_mismatch("rotor_angle", out_rotor_angle, rotor_want.angle);
        if (out_rotor_speed !== rotor_want.speed)
          report_mismatch("rotor_speed", out_rotor_speed, rotor_want.speed);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", rotor_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                            roll;
    int                            rotor_sector;
    bit                            spin_fwd;
    logic                          cmd;
    logic [hsai_pkg::PERIOD_W-1:0] period;
    logic [hsai_pkg::CODE_W-1:0]   code;
    logic [hsai_pkg::INC_W-1:0]    inc_val;
    logic [hsai_pkg::SPEED_W-1:0]  spd_val;
    logic [hsai_pkg::OFFSET_W-1:0] ofs_val;

    hall_seq = '{hsai_pkg::HALL_S0, hsai_pkg::HALL_S1, hsai_pkg::HALL_S2,
                 hsai_pkg::HALL_S3, hsai_pkg::HALL_S4, hsai_pkg::HALL_S5};

    // hand-typed rows sit on reset values, saturation and the wrap;
    // the rest are left to the predictor
    directed_rows = '{
      // tick from reset
      '{1'b1, hsai_pkg::CMD_TICK,    16'hFFFF, hsai_pkg::HALL_S0, 16'd0,     26'd0},
      // nothing to update
      '{1'b1, hsai_pkg::CMD_CAPTURE, 16'd0,    HALL_BAD_LO,       16'd0,     26'd0},
      '{1'b1, hsai_pkg::CMD_CAPTURE, 16'd0,    HALL_BAD_HI,       16'd0,     26'd0},
      // step saturates
      '{1'b1, hsai_pkg::CMD_CAPTURE, 16'd1,    hsai_pkg::HALL_S0, 16'd40050, 26'd50000000},
      // wraps past a turn
      '{1'b1, hsai_pkg::CMD_TICK,    16'd0,    HALL_BAD_LO,       16'd40049, 26'd50000000},
      // snap, keep step
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd0,    hsai_pkg::HALL_S1, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'h5555, HALL_BAD_HI,       16'd0,     26'd0},
      // longest period
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'hFFFF, HALL_BAD_HI,       16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'd0,    hsai_pkg::HALL_S2, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd1000, hsai_pkg::HALL_S2, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'hAAAA, hsai_pkg::HALL_S3, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'd0,    HALL_BAD_LO,       16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'hAAAA, hsai_pkg::HALL_S3, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'h5555, hsai_pkg::HALL_S4, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd12345, hsai_pkg::HALL_S5, 16'd0,    26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'd0,    HALL_BAD_LO,       16'd0,     26'd0},
      // bad code, new step
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd7,    HALL_BAD_LO,       16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'd0,    HALL_BAD_LO,       16'd0,     26'd0},
      // just under the limit
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd167,  hsai_pkg::HALL_S0, 16'd0,     26'd0},
      // just over it
      '{1'b0, hsai_pkg::CMD_CAPTURE, 16'd166,  hsai_pkg::HALL_S1, 16'd0,     26'd0},
      '{1'b0, hsai_pkg::CMD_TICK,    16'd0,    HALL_BAD_LO,       16'd0,     26'd0}
    };

    rotor_sector = 0;
    spin_fwd     = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      // idling pattern: none, sender only, receiver only, both lightly
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < N_DIRECTED; i++)
          send_item(directed_rows[i].cmd, directed_rows[i].period, directed_rows[i].code,
                    directed_rows[i].has_value,
                    '{directed_rows[i].angle, directed_rows[i].speed});
      end else begin
        // registers change only once every pending result has come out
        while (rotor_expect_q.size() != 0) @(posedge clk);
        case (phase)
          1: begin inc_val = '1; spd_val = '1; ofs_val = '1; end
          2: begin inc_val = '0; spd_val = '0; ofs_val = '0; end
          6: begin
            inc_val = hsai_pkg::INC_SCALE_RST;
            spd_val = hsai_pkg::SPD_SCALE_RST;
            ofs_val = hsai_pkg::PHASE_OFS_RST;
          end
          default: begin
            inc_val = hsai_pkg::INC_W'($urandom);
            spd_val = hsai_pkg::SPEED_W'($urandom);
            ofs_val = hsai_pkg::OFFSET_W'($urandom);
          end
        endcase
        write_setting(hsai_pkg::REG_INC_SCALE, hsai_pkg::CFG_DATA_W'(inc_val));
        write_setting(hsai_pkg::REG_SPD_SCALE, hsai_pkg::CFG_DATA_W'(spd_val));
        write_setting(hsai_pkg::REG_PHASE_OFS, hsai_pkg::CFG_DATA_W'(ofs_val));
        cfg_valid <= 1'b0;
      end

      // mostly commutation in order with ticks between, some bad codes and odd periods
      repeat (ITEMS_PER_PHASE) begin
        roll   = $urandom_range(0, 99);
        cmd    = (roll < 55) ? hsai_pkg::CMD_TICK : hsai_pkg::CMD_CAPTURE;
        period = hsai_pkg::PERIOD_W'($urandom);
        code   = hsai_pkg::CODE_W'($urandom);
        if (cmd == hsai_pkg::CMD_CAPTURE) begin
          case ($urandom_range(0, 9))
            0:       period = '0;
            1:       period = '1;
            2:       period = hsai_pkg::PERIOD_W'($urandom_range(1, 200));
            3, 4, 5: period = hsai_pkg::PERIOD_W'($urandom_range(200, 5000));
            default: ;
          endcase
          if (roll < 90) begin
            if ($urandom_range(0, 15) == 0) spin_fwd = !spin_fwd;
            rotor_sector = (rotor_sector + (spin_fwd ? 1 : 5)) % 6;
            code = hall_seq[rotor_sector];
          end else begin
            code = $urandom_range(0, 1) ? HALL_BAD_HI : HALL_BAD_LO;
          end
        end
        send_item(cmd, period, code, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    // drain, then give the block time to show any stray result
    while (rotor_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
